### sv/ljds_pkg.sv
// ----------------------------------------------------------------------------
// ljds_pkg: shared types and constants of the jump distance segmenter
// Register indexes, reset values, datapath widths and the beat layouts
// exchanged between the front queue, the back sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ljds_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int COORD_WIDTH_DEF  = 24;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_THRESHOLD_MODE = 3'd0,
    CFG_JUMP_THRESHOLD = 3'd1,
    CFG_NOISE_OFFSET   = 3'd2,
    CFG_CHORD_COEFF    = 3'd3,
    CFG_SANTOS_SCALE   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIXED     = 2'd0,
    MODE_LEE       = 2'd1,
    MODE_DIETMAYER = 2'd2,
    MODE_SANTOS    = 2'd3
  } thr_mode_e;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] JUMP_THRESHOLD_RST = 24'd4096;
  localparam logic [19:0] SANTOS_SCALE_RST   = 20'd65536;

  // arithmetic widths: squares, roots, shift-add multiplier operands
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 34;
  localparam int PROD_W    = 74;
  localparam int FRAC_W    = 16;
  localparam int LEE_SHIFT = 12;

  localparam int SEG_IDX_W = 10;
  localparam int SEG_CNT_W = 11;
  localparam int OUT_DATA_W = 24;

  // per item flags classified by the front
  typedef struct packed {
    logic valid;
    logic last;
  } item_flags_t;

  // result data, lowest field in the lowest bits
  typedef struct packed {
    logic [SEG_CNT_W-1:0] segment_count;
    logic                 wrap_merged;
    logic                 point_dropped;
    logic                 starts_segment;
    logic [SEG_IDX_W-1:0] segment_index;
  } res_data_t;

  typedef enum logic {
    KIND_LABEL   = 1'b0,
    KIND_SUMMARY = 1'b1
  } res_kind_e;

  typedef struct packed {
    res_kind_e kind;
    logic      last;
    res_data_t data;
  } out_beat_t;

endpackage

`default_nettype wire

### sv/ljds_front.sv
// ----------------------------------------------------------------------------
// ljds_front: input acceptance and item queue
// Accepts point beats, splits them into coordinates and flags and holds
// them in a two entry queue that the back sequencer drains.
// ----------------------------------------------------------------------------
`default_nettype none

module ljds_front #(
  parameter int COORD_WIDTH = 24,
  localparam int IN_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                   s_axis_tuser,
  input  wire logic                   s_axis_tlast,
  output      logic                   item_avail_o,
  input  wire logic                   item_pop_i,
  output      logic [COORD_WIDTH-1:0] item_x_o,
  output      logic [COORD_WIDTH-1:0] item_y_o,
  output      ljds_pkg::item_flags_t  item_flags_o
);
  import ljds_pkg::*;

  logic [COORD_WIDTH-1:0] x_mem [2];
  logic [COORD_WIDTH-1:0] y_mem [2];
  item_flags_t            f_mem [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   push;

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_avail_o  = (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = item_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !item_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && item_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      x_mem[wr_ptr_q] <= s_axis_tdata[COORD_WIDTH-1:0];
      y_mem[wr_ptr_q] <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      f_mem[wr_ptr_q] <= '{valid: s_axis_tuser, last: s_axis_tlast};
    end
  end

  assign item_x_o     = x_mem[rd_ptr_q];
  assign item_y_o     = y_mem[rd_ptr_q];
  assign item_flags_o = f_mem[rd_ptr_q];

endmodule

`default_nettype wire

### sv/ljds_back.sv
// ----------------------------------------------------------------------------
// ljds_back: segmentation sequencer
// Pulls items from the queue, measures ranges and jump distances with a
// bit-serial square root and a shift-add multiplier, labels points, emits
// the end of scan summary and keeps the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ljds_back #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_WIDTH  = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ljds_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ljds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                        item_avail_i,
  output      logic                        item_pop_o,
  input  wire logic [COORD_WIDTH-1:0]      item_x_i,
  input  wire logic [COORD_WIDTH-1:0]      item_y_i,
  input  wire ljds_pkg::item_flags_t       item_flags_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      ljds_pkg::out_beat_t         out_beat_o
);
  import ljds_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int DW    = (COORD_WIDTH + 1 > 32) ? 32 : COORD_WIDTH + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [SQ_W-1:0]  DIFF_SAT = SQ_W'(64'h8000_0000);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_RSQX    = 13'b0000000000010,
    S_RSQY    = 13'b0000000000100,
    S_SQRT    = 13'b0000000001000,
    S_DIFF    = 13'b0000000010000,
    S_DSQX    = 13'b0000000100000,
    S_DSQY    = 13'b0000001000000,
    S_DECIDE  = 13'b0000010000000,
    S_MUL     = 13'b0000100000000,
    S_MULDONE = 13'b0001000000000,
    S_APPLY   = 13'b0010000000000,
    S_SUMCHK  = 13'b0100000000000,
    S_SUMOUT  = 13'b1000000000000
  } state_e;

  typedef enum logic [2:0] {
    MT_LEE  = 3'd0,
    MT_DIET = 3'd1,
    MT_S1   = 3'd2,
    MT_S2   = 3'd3,
    MT_S3   = 3'd4,
    MT_S4   = 3'd5
  } mul_tag_e;

  state_e    state_q, state_d;
  mul_tag_e  tag_q, tag_d;

  // configuration
  thr_mode_e   mode_q;
  logic [23:0] jthr_q;
  logic [23:0] noise_q;
  logic [17:0] chord_q;
  logic [19:0] scale_q;

  // scan state
  logic [COORD_WIDTH-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [COORD_WIDTH-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [ROOT_W-1:0]      prev_r_q, prev_r_d, first_r_q, first_r_d;
  logic                   prev_pres_q, prev_pres_d, first_pres_q, first_pres_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  // work registers
  logic [COORD_WIDTH-1:0] it_x_q, it_x_d, it_y_q, it_y_d;
  item_flags_t            it_f_q, it_f_d;
  logic                   sum_q, sum_d;
  logic                   jump_q, jump_d;
  logic                   sqrt_dist_q, sqrt_dist_d;
  logic [ROOT_W-1:0]      r_new_q, r_new_d, dist_q, dist_d;
  logic [DW-1:0]          dx_q, dx_d, dy_q, dy_d;
  logic [SQ_W-1:0]        sq_q, sq_d, rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [PROD_W-1:0]      ma_q, ma_d, acc_q, acc_d, p1_q, p1_d;
  logic [MUL_B_W-1:0]     mb_q, mb_d;
  logic [MUL_A_W-1:0]     b_q, b_d;

  logic                   out_valid_q, out_valid_d;
  out_beat_t              out_q, out_d;

  // combinational helpers
  logic [COORD_WIDTH-1:0] p2x, p2y, mx, my;
  logic [ROOT_W-1:0]      r1, r2, minr, rdiff;
  logic [ROOT_W:0]        rsum;
  logic [ROOT_W+LEE_SHIFT-1:0] lee_n;
  logic [COORD_WIDTH:0]   dfx, dfy, dmx, dmy;
  logic [SQ_W-1:0]        dmx_ext, dmy_ext, dsx, dsy;
  logic [31:0]            sq_op;
  logic [SQ_W-1:0]        sq_prod, trial;
  logic                   slot_free;
  logic                   mul_go;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [CNT_W-1:0]       cnt_new;
  state_e                 eval_next;

  assign p2x  = sum_q ? first_x_q : it_x_q;
  assign p2y  = sum_q ? first_y_q : it_y_q;
  assign r1   = prev_r_q;
  assign r2   = sum_q ? first_r_q : r_new_q;
  assign minr = (r1 < r2) ? r1 : r2;
  assign rdiff = (r1 > r2) ? (r1 - r2) : (r2 - r1);
  assign rsum = {1'b0, r1} + {1'b0, r2};
  assign lee_n = {rdiff, {LEE_SHIFT{1'b0}}};

  assign mx = it_x_q[COORD_WIDTH-1] ? (~it_x_q + 1'b1) : it_x_q;
  assign my = it_y_q[COORD_WIDTH-1] ? (~it_y_q + 1'b1) : it_y_q;

  assign dfx = {p2x[COORD_WIDTH-1], p2x} - {prev_x_q[COORD_WIDTH-1], prev_x_q};
  assign dfy = {p2y[COORD_WIDTH-1], p2y} - {prev_y_q[COORD_WIDTH-1], prev_y_q};
  assign dmx = dfx[COORD_WIDTH] ? (~dfx + 1'b1) : dfx;
  assign dmy = dfy[COORD_WIDTH] ? (~dfy + 1'b1) : dfy;
  assign dmx_ext = SQ_W'(dmx);
  assign dmy_ext = SQ_W'(dmy);
  // clamp differences at 2^31
  assign dsx = (dmx_ext > DIFF_SAT) ? DIFF_SAT : dmx_ext;
  assign dsy = (dmy_ext > DIFF_SAT) ? DIFF_SAT : dmy_ext;

  always_comb begin
    unique case (state_q)
      S_RSQX:  sq_op = 32'(mx);
      S_RSQY:  sq_op = 32'(my);
      S_DSQX:  sq_op = 32'(dx_q);
      default: sq_op = 32'(dy_q);
    endcase
  end
  assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);
  assign trial   = root_q + bit_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign eval_next = sum_q ? S_SUMOUT : S_APPLY;
  assign cnt_new   = (it_f_q.valid && jump_q && (cnt_q < CNT_MAX)) ? (cnt_q + 1'b1) : cnt_q;

  always_comb begin
    state_d      = state_q;
    tag_d        = tag_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    prev_r_d     = prev_r_q;
    first_r_d    = first_r_q;
    prev_pres_d  = prev_pres_q;
    first_pres_d = first_pres_q;
    cnt_d        = cnt_q;
    it_x_d       = it_x_q;
    it_y_d       = it_y_q;
    it_f_d       = it_f_q;
    sum_d        = sum_q;
    jump_d       = jump_q;
    sqrt_dist_d  = sqrt_dist_q;
    r_new_d      = r_new_q;
    dist_d       = dist_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    sq_d         = sq_q;
    rem_d        = rem_q;
    root_d       = root_q;
    bit_d        = bit_q;
    ma_d         = ma_q;
    mb_d         = mb_q;
    acc_d        = acc_q;
    p1_d         = p1_q;
    b_d          = b_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    item_pop_o   = 1'b0;
    mul_go       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_avail_i) begin
          item_pop_o = 1'b1;
          it_x_d     = item_x_i;
          it_y_d     = item_y_i;
          it_f_d     = item_flags_i;
          state_d    = item_flags_i.valid ? S_RSQX : S_APPLY;
        end
      end
      S_RSQX: begin
        sq_d    = sq_prod;
        state_d = S_RSQY;
      end
      S_RSQY: begin
        rem_d       = sq_q + sq_prod;
        root_d      = '0;
        bit_d       = SQ_W'(1) << (SQ_W - 2);
        sqrt_dist_d = 1'b0;
        state_d     = S_SQRT;
      end
      S_SQRT: begin
        // one result bit per cycle
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          if (sqrt_dist_q) begin
            dist_d  = root_d[ROOT_W-1:0];
            state_d = S_DECIDE;
          end else begin
            r_new_d = root_d[ROOT_W-1:0];
            if (!prev_pres_q) begin
              jump_d  = 1'b1;
              state_d = S_APPLY;
            end else begin
              state_d = S_DIFF;
            end
          end
        end
      end
      S_DIFF: begin
        dx_d    = dsx[DW-1:0];
        dy_d    = dsy[DW-1:0];
        state_d = S_DSQX;
      end
      S_DSQX: begin
        sq_d    = sq_prod;
        state_d = S_DSQY;
      end
      S_DSQY: begin
        rem_d       = sq_q + sq_prod;
        root_d      = '0;
        bit_d       = SQ_W'(1) << (SQ_W - 2);
        sqrt_dist_d = 1'b1;
        state_d     = S_SQRT;
      end
      S_DECIDE: begin
        unique case (mode_q)
          MODE_FIXED: begin
            jump_d  = (dist_q > ROOT_W'(jthr_q));
            state_d = eval_next;
          end
          MODE_LEE: begin
            if (rsum == '0) begin
              jump_d  = (dist_q != '0);
              state_d = eval_next;
            end else begin
              mul_go  = 1'b1;
              mul_a   = MUL_A_W'(rsum);
              mul_b   = MUL_B_W'(dist_q);
              tag_d   = MT_LEE;
              state_d = S_MUL;
            end
          end
          MODE_DIETMAYER: begin
            mul_go  = 1'b1;
            mul_a   = MUL_A_W'(minr);
            mul_b   = MUL_B_W'(chord_q);
            tag_d   = MT_DIET;
            state_d = S_MUL;
          end
          default: begin
            // no horizontal step, or inside the noise band: never a jump
            if (dx_q == '0 || dist_q <= ROOT_W'(noise_q)) begin
              jump_d  = 1'b0;
              state_d = eval_next;
            end else begin
              mul_go  = 1'b1;
              mul_a   = MUL_A_W'(minr);
              mul_b   = MUL_B_W'(chord_q);
              tag_d   = MT_S1;
              state_d = S_MUL;
            end
          end
        endcase
      end
      S_MUL: begin
        if (mb_q == '0) begin
          state_d = S_MULDONE;
        end else begin
          if (mb_q[0]) begin
            acc_d = acc_q + ma_q;
          end
          ma_d = ma_q << 1;
          mb_d = mb_q >> 1;
        end
      end
      S_MULDONE: begin
        unique case (tag_q)
          MT_LEE: begin
            jump_d  = (acc_q > PROD_W'(lee_n));
            state_d = eval_next;
          end
          MT_DIET: begin
            jump_d  = (PROD_W'(dist_q) > (PROD_W'(noise_q) + (acc_q >> FRAC_W)));
            state_d = eval_next;
          end
          MT_S1: begin
            mul_go  = 1'b1;
            mul_a   = MUL_A_W'(acc_q >> FRAC_W);
            mul_b   = MUL_B_W'(scale_q);
            tag_d   = MT_S2;
            state_d = S_MUL;
          end
          MT_S2: begin
            b_d     = MUL_A_W'(acc_q >> FRAC_W);
            mul_go  = 1'b1;
            mul_a   = MUL_A_W'(dist_q - ROOT_W'(noise_q));
            mul_b   = MUL_B_W'(dx_q);
            tag_d   = MT_S3;
            state_d = S_MUL;
          end
          MT_S3: begin
            p1_d    = acc_q;
            mul_go  = 1'b1;
            mul_a   = b_q;
            mul_b   = MUL_B_W'(dy_q);
            tag_d   = MT_S4;
            state_d = S_MUL;
          end
          default: begin
            jump_d  = (p1_q > acc_q);
            state_d = eval_next;
          end
        endcase
      end
      S_APPLY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = KIND_LABEL;
          out_d.last  = !it_f_q.last;
          out_d.data  = '0;
          out_d.data.point_dropped = !it_f_q.valid;
          if (it_f_q.valid) begin
            out_d.data.starts_segment = jump_q;
            out_d.data.segment_index  = SEG_IDX_W'(cnt_new - 1'b1);
            cnt_d       = cnt_new;
            prev_x_d    = it_x_q;
            prev_y_d    = it_y_q;
            prev_r_d    = r_new_q;
            prev_pres_d = 1'b1;
            if (!first_pres_q) begin
              first_x_d    = it_x_q;
              first_y_d    = it_y_q;
              first_r_d    = r_new_q;
              first_pres_d = 1'b1;
            end
          end
          state_d = it_f_q.last ? S_SUMCHK : S_IDLE;
        end
      end
      S_SUMCHK: begin
        if (cnt_q >= CNT_W'(2) && prev_pres_q && first_pres_q) begin
          sum_d   = 1'b1;
          state_d = S_DIFF;
        end else begin
          jump_d  = 1'b1;
          state_d = S_SUMOUT;
        end
      end
      S_SUMOUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = KIND_SUMMARY;
          out_d.last  = 1'b1;
          out_d.data  = '0;
          out_d.data.wrap_merged   = !jump_q;
          out_d.data.segment_count = jump_q ? SEG_CNT_W'(cnt_q)
                                            : SEG_CNT_W'(cnt_q - 1'b1);
          // back to an empty scan
          cnt_d        = '0;
          prev_x_d     = '0;
          prev_y_d     = '0;
          first_x_d    = '0;
          first_y_d    = '0;
          prev_pres_d  = 1'b0;
          first_pres_d = 1'b0;
          sum_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (mul_go) begin
      ma_d  = PROD_W'(mul_a);
      mb_d  = mul_b;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tag_q        <= MT_LEE;
      mode_q       <= MODE_FIXED;
      jthr_q       <= JUMP_THRESHOLD_RST;
      noise_q      <= '0;
      chord_q      <= '0;
      scale_q      <= SANTOS_SCALE_RST;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_r_q     <= '0;
      first_r_q    <= '0;
      prev_pres_q  <= 1'b0;
      first_pres_q <= 1'b0;
      cnt_q        <= '0;
      sum_q        <= 1'b0;
      sqrt_dist_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tag_q        <= tag_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      first_x_q    <= first_x_d;
      first_y_q    <= first_y_d;
      prev_r_q     <= prev_r_d;
      first_r_q    <= first_r_d;
      prev_pres_q  <= prev_pres_d;
      first_pres_q <= first_pres_d;
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
      sqrt_dist_q  <= sqrt_dist_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_THRESHOLD_MODE: mode_q  <= thr_mode_e'(cfg_wdata_i[1:0]);
          CFG_JUMP_THRESHOLD: jthr_q  <= cfg_wdata_i[23:0];
          CFG_NOISE_OFFSET:   noise_q <= cfg_wdata_i[23:0];
          CFG_CHORD_COEFF:    chord_q <= cfg_wdata_i[17:0];
          CFG_SANTOS_SCALE:   scale_q <= cfg_wdata_i[19:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    it_x_q  <= it_x_d;
    it_y_q  <= it_y_d;
    it_f_q  <= it_f_d;
    jump_q  <= jump_d;
    r_new_q <= r_new_d;
    dist_q  <= dist_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    acc_q   <= acc_d;
    p1_q    <= p1_d;
    b_q     <= b_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

### sv/lidar_jump_distance_segmenter_unit.sv
// ----------------------------------------------------------------------------
// lidar_jump_distance_segmenter_unit: jump distance segmentation of a scan
// Labels radially ordered scan points with segment indexes and closes each
// scan with a summary that reports the wrap merge and the segment count.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on the s_axis channel, one point per beat; tlast marks the
//   final point of a scan. Each point gives one label beat on m_axis; the
//   final point gives a label and then a summary beat, which carries tlast.
//   Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i while
//   the block is idle; writes take effect on the next edge.
//   A two beat queue takes points while the back sequencer is busy.
//   Per point: a dropped point is popped and labelled. A valid point first
//   has its range worked out (pop, two squares, a 32 step square root at
//   one bit a cycle, label); with a previous point, the distance to it is
//   worked out the same way, plus in Lee mode one shift-add multiply unless
//   both ranges are zero, in Dietmayer mode one and in Santos mode up to
//   four. A scan end adds a check and the summary beat, and one more
//   distance evaluation when the scan holds two or more segments.
//   Points are handled one at a time.
//   While m_axis_tready is low the output beat holds and the sequencer waits;
//   the queue fills and then s_axis_tready drops.
//   Reset clears the scan state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_jump_distance_segmenter_unit #(
  parameter int MAX_SEGMENTS = ljds_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH  = ljds_pkg::COORD_WIDTH_DEF,
  localparam int IN_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ljds_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ljds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // point_x, point_y
  input  wire logic [IN_DATA_W-1:0]            s_axis_tdata,
  // point_valid
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // segment_index, starts_segment, point_dropped, wrap_merged, segment_count
  output      logic [ljds_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind
  output      logic                            m_axis_tuser,
  output      logic                            m_axis_tlast
);
  import ljds_pkg::*;

  logic                   item_avail, item_pop;
  logic [COORD_WIDTH-1:0] item_x, item_y;
  item_flags_t            item_flags;
  out_beat_t              beat;

  ljds_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .item_avail_o (item_avail),
    .item_pop_i   (item_pop),
    .item_x_o     (item_x),
    .item_y_o     (item_y),
    .item_flags_o (item_flags)
  );

  ljds_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_avail_i(item_avail),
    .item_pop_o  (item_pop),
    .item_x_i    (item_x),
    .item_y_i    (item_y),
    .item_flags_i(item_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (beat)
  );

  assign m_axis_tdata = beat.data;
  assign m_axis_tuser = beat.kind;
  assign m_axis_tlast = beat.last;

endmodule

`default_nettype wire

### sv/ljds_checker.sv
// ----------------------------------------------------------------------------
// ljds_checker: output channel checks
// Watches the result channel for held beats and for field layouts that
// labels and summaries must keep.
// ----------------------------------------------------------------------------
`default_nettype none

module ljds_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [ljds_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser,
  input wire logic                            m_axis_tlast
);
  import ljds_pkg::*;

  res_data_t d;
  assign d = m_axis_tdata;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("summary without last marker");

  a_label_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !d.wrap_merged && d.segment_count == '0)
    else $error("label carries summary fields");

  a_sum_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      d.segment_index == '0 && !d.starts_segment && !d.point_dropped)
    else $error("summary carries label fields");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && d.point_dropped |->
      d.segment_index == '0 && !d.starts_segment)
    else $error("dropped point has a segment");

endmodule

bind lidar_jump_distance_segmenter_unit ljds_checker u_ljds_checker (.*);

`default_nettype wire

### tb/sv/lidar_jump_distance_segmenter_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_jump_distance_segmenter_unit_checker: label and summary scoreboard
// Watches the register port and both stream channels. It keeps its own copy
// of the registers and the scan state, works out the label and summary beats
// of every accepted point, and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_jump_distance_segmenter_unit_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ljds_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ljds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [47:0]                     s_axis_tdata,
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [ljds_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                            m_axis_tuser,
  input  wire logic                            m_axis_tlast,
  output int                                   errors_o,
  output int                                   pending_o
);
  import ljds_pkg::*;

  typedef struct {
    res_kind_e                kind;
    logic [SEG_IDX_W-1:0]     index;
    logic                     starts;
    logic                     dropped;
    logic                     wrap;
    logic [SEG_CNT_W-1:0]     count;
    logic                     last;
  } seg_beat_t;

  seg_beat_t expected_beats[$];

  thr_mode_e   mode_q;
  logic [23:0] jump_thr_q, noise_q;
  logic [17:0] chord_q;
  logic [19:0] santos_q;

  longint prev_x, prev_y, first_x, first_y;
  bit     prev_seen, first_seen;
  int     seg_cnt;
  int     err_cnt;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_sat(longint v);
    longint unsigned a = (v < 0) ? -v : v;
    return (a > 64'h8000_0000) ? 64'h8000_0000 : a;
  endfunction

  function automatic bit is_jump(longint x1, longint y1, longint x2, longint y2);
    longint unsigned dx = abs_sat(x2 - x1);
    longint unsigned dy = abs_sat(y2 - y1);
    longint unsigned span = int_sqrt(dx * dx + dy * dy);
    longint unsigned r1 = int_sqrt(abs_sat(x1) * abs_sat(x1) + abs_sat(y1) * abs_sat(y1));
    longint unsigned r2 = int_sqrt(abs_sat(x2) * abs_sat(x2) + abs_sat(y2) * abs_sat(y2));
    longint unsigned minr = (r1 < r2) ? r1 : r2;
    longint unsigned thr, b;
    logic [127:0] lhs, rhs;
    case (mode_q)
      MODE_LEE: begin
        thr = (r1 + r2 == 0) ? 0 : (((r1 > r2) ? r1 - r2 : r2 - r1) * 4096) / (r1 + r2);
        return span > thr;
      end
      MODE_DIETMAYER: begin
        thr = noise_q + ((chord_q * minr) >> 16);
        return span > thr;
      end
      MODE_SANTOS: begin
        // vertical step: the ratio is unbounded, treat as continuous
        if (dx == 0) return 0;
        if (span <= noise_q) return 0;
        b = (((chord_q * minr) >> 16) * santos_q) >> 16;
        lhs = {64'd0, span - noise_q} * {64'd0, dx};
        rhs = {64'd0, b} * {64'd0, dy};
        return lhs > rhs;
      end
      default: return span > jump_thr_q;
    endcase
  endfunction

  task automatic clear_scan();
    prev_x = 0; prev_y = 0; first_x = 0; first_y = 0;
    prev_seen = 0; first_seen = 0;
    seg_cnt = 0;
  endtask

  task automatic predict_point(logic [47:0] data, logic valid, logic last);
    seg_beat_t lbl, sum;
    longint x, y;
    bit jmp;
    lbl = '{KIND_LABEL, '0, 1'b0, !valid, 1'b0, '0, !last};
    if (valid) begin
      x = longint'(signed'(data[23:0]));
      y = longint'(signed'(data[47:24]));
      jmp = !prev_seen || is_jump(prev_x, prev_y, x, y);
      if (jmp) begin
        lbl.starts = 1'b1;
        if (seg_cnt < MAX_SEGMENTS_DEF) seg_cnt++;
      end
      lbl.index = SEG_IDX_W'(seg_cnt - 1);
      if (!first_seen) begin
        first_x = x;
        first_y = y;
        first_seen = 1;
      end
      prev_x = x;
      prev_y = y;
      prev_seen = 1;
    end
    expected_beats = {expected_beats, lbl};
    if (last) begin
      sum = '{KIND_SUMMARY, '0, 1'b0, 1'b0, 1'b0, SEG_CNT_W'(seg_cnt), 1'b1};
      // a lone segment never merges with itself
      if (seg_cnt >= 2 && !is_jump(prev_x, prev_y, first_x, first_y)) begin
        sum.wrap = 1'b1;
        sum.count = SEG_CNT_W'(seg_cnt - 1);
      end
      expected_beats = {expected_beats, sum};
      clear_scan();
    end
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_beat();
    seg_beat_t e;
    if (expected_beats.size() == 0) begin
      $error("output beat with nothing expected");
      err_cnt++;
      return;
    end
    e = expected_beats.pop_front();
    check_field("result_kind", e.kind, m_axis_tuser);
    check_field("segment_index", e.index, m_axis_tdata[9:0]);
    check_field("starts_segment", e.starts, m_axis_tdata[10]);
    check_field("point_dropped", e.dropped, m_axis_tdata[11]);
    check_field("wrap_merged", e.wrap, m_axis_tdata[12]);
    check_field("segment_count", e.count, m_axis_tdata[23:13]);
    check_field("last_result", e.last, m_axis_tlast);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     = MODE_FIXED;
      jump_thr_q = JUMP_THRESHOLD_RST;
      noise_q    = '0;
      chord_q    = '0;
      santos_q   = SANTOS_SCALE_RST;
      clear_scan();
      expected_beats.delete();
      err_cnt    = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready) predict_point(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_THRESHOLD_MODE: mode_q = thr_mode_e'(cfg_wdata_i[1:0]);
          CFG_JUMP_THRESHOLD: jump_thr_q = cfg_wdata_i;
          CFG_NOISE_OFFSET:   noise_q = cfg_wdata_i;
          CFG_CHORD_COEFF:    chord_q = cfg_wdata_i[17:0];
          CFG_SANTOS_SCALE:   santos_q = cfg_wdata_i[19:0];
          default: ;
        endcase
      end
      errors_o  <= err_cnt;
      pending_o <= expected_beats.size();
    end
  end

endmodule

`default_nettype wire

### tb/sv/lidar_jump_distance_segmenter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_jump_distance_segmenter_unit_test: segmenter stimulus and verdict
// Drives directed scans, then random scans of random-walk points under many
// register settings, with random gaps on the input and random output stalls.
// The checker beside the block scores every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_jump_distance_segmenter_unit_test;
  import ljds_pkg::*;

  localparam int DRAIN_CYCLES = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // point_x, point_y
  logic        s_axis_tuser = 1'b0; // point_valid
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata; // segment_index, starts_segment,
                                       // point_dropped, wrap_merged, segment_count
  logic        m_axis_tuser;           // result_kind
  logic        m_axis_tlast;
  int          errors, pending;
  bit          stall_en = 1'b1;
  int          stall_left = 0;

  lidar_jump_distance_segmenter_unit u_dut (.*);

  lidar_jump_distance_segmenter_unit_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output stall: low for a random stretch, then high for a random stretch
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_en || m_axis_tready == 1'b0) begin
      m_axis_tready <= 1'b1;
      stall_left <= stall_en ? $urandom_range(0, 8) : 0;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= gap_len();
    end
  end

  task automatic send_point(logic [23:0] x, logic [23:0] y, logic valid, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop the input and let every expected beat drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(thr_mode_e mode, logic [23:0] thr, logic [23:0] c0,
                            logic [17:0] c1, logic [19:0] scale);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_THRESHOLD_MODE; cfg_wdata_i <= 24'(mode);
    @(posedge clk_i);
    cfg_addr_i <= CFG_JUMP_THRESHOLD; cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_addr_i <= CFG_NOISE_OFFSET; cfg_wdata_i <= c0;
    @(posedge clk_i);
    cfg_addr_i <= CFG_CHORD_COEFF; cfg_wdata_i <= 24'(c1);
    @(posedge clk_i);
    cfg_addr_i <= CFG_SANTOS_SCALE; cfg_wdata_i <= 24'(scale);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one scan as a random walk; bursts of big steps make jumps
  task automatic random_scan(int len, int step_max, bit wide);
    logic [23:0] x, y;
    int kind;
    x = wide ? 24'($urandom) : 24'($urandom_range(0, 200000) - 100000);
    y = wide ? 24'($urandom) : 24'($urandom_range(0, 200000) - 100000);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        x = 24'($urandom); y = 24'($urandom);
      end else if (kind < 25) begin
        x += 24'($urandom_range(0, 40000) - 20000);
        y += 24'($urandom_range(0, 40000) - 20000);
      end else if (kind < 30) begin
        y += 24'($urandom_range(0, 2 * step_max) - step_max);
      end else begin
        x += 24'($urandom_range(0, 2 * step_max) - step_max);
        y += 24'($urandom_range(0, 2 * step_max) - step_max);
      end
      // invalid points carry random coordinates that must be ignored
      if ($urandom_range(0, 99) < 10)
        send_point(24'($urandom), 24'($urandom), 1'b0, i == len - 1);
      else
        send_point(x, y, 1'b1, i == len - 1);
    end
  endtask

  initial begin
    thr_mode_e mode;
    logic [23:0] thr, c0;
    logic [17:0] c1;
    logic [19:0] scale;
    int sent;
    logic [23:0] sx;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: fixed 1 m; first point opens, near point stays, far point jumps
    send_point(24'd0, 24'd0, 1'b1, 1'b0);
    send_point(24'd100, 24'd0, 1'b1, 1'b0);
    send_point(24'd9000, 24'd0, 1'b1, 1'b0);
    send_point(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0);
    send_point(24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
    send_point(24'h7FFFFF, 24'h800000, 1'b1, 1'b0);
    send_point(24'd50, 24'd50, 1'b1, 1'b1);          // wraps onto the first point
    send_point(24'd0, 24'd0, 1'b0, 1'b1);            // empty scan
    send_point(24'd5, 24'd5, 1'b1, 1'b0);            // lone segment
    send_point(24'd6, 24'd5, 1'b1, 1'b1);
    wait_idle();
    write_regs(MODE_SANTOS, 24'd0, 24'd0, 18'd1146, 20'd66700);
    send_point(24'd40000, 24'd0, 1'b1, 1'b0);        // vertical step never jumps
    send_point(24'd40000, 24'd900000, 1'b1, 1'b0);
    send_point(24'd50000, 24'd900000, 1'b1, 1'b1);
    wait_idle();
    write_regs(MODE_LEE, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF, 20'hFFFFF);
    send_point(24'd0, 24'd0, 1'b1, 1'b0);            // both ranges zero
    send_point(24'd0, 24'd0, 1'b1, 1'b0);
    send_point(24'd3, 24'd0, 1'b1, 1'b1);
    wait_idle();
    write_regs(MODE_DIETMAYER, 24'd0, 24'hFFFFFF, 18'h3FFFF, 20'd0);
    send_point(24'h800000, 24'h800000, 1'b1, 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1);
    wait_idle();

    // saturate the segment index: every distinct point jumps at threshold 0
    write_regs(MODE_FIXED, 24'd0, 24'd0, 18'd0, 20'd0);
    sx = 24'd0;
    for (int i = 0; i < 1040; i++) begin
      sx += 24'd7;
      send_point(sx, 24'(i), 1'b1, i == 1039);
    end
    wait_idle();

    sent = 0;
    for (int p = 0; sent < 450; p++) begin
      mode  = thr_mode_e'(p % 4);
      thr   = (p % 9 == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 12000));
      c0    = (p % 7 == 3) ? 24'hFFFFFF : 24'($urandom_range(0, 800));
      c1    = (p % 5 == 2) ? 18'h3FFFF : 18'($urandom_range(0, 6000));
      scale = (p % 6 == 1) ? 20'hFFFFF : (p % 6 == 4) ? 20'd0
                                       : 20'($urandom_range(65536, 80000));
      if (p % 10 == 5) c1 = 18'($urandom);
      if (p % 10 == 7) c0 = 24'($urandom);
      stall_en = (p % 5 != 0);
      write_regs(mode, thr, c0, c1, scale);
      for (int s = 0; s < 6; s++) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
        random_scan(len, (p % 3 == 0) ? 60 : 3000, $urandom_range(0, 9) == 0);
        sent += len;
      end
      wait_idle();
    end

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/ljds_pkg.sv
sv/ljds_front.sv
sv/ljds_back.sv
sv/lidar_jump_distance_segmenter_unit.sv
sv/ljds_checker.sv
tb/sv/lidar_jump_distance_segmenter_unit_checker.sv
tb/sv/lidar_jump_distance_segmenter_unit_test.sv
